// File: hdl/scf_pkg.sv
// Shared types, constants and helper functions of the scan crossing finder.
`timescale 1ns / 1ps

package scf_pkg;

    localparam int COORD_W     = 32;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 88;
    localparam int SPAN_W      = 23;
    localparam int IDX_OUT_W   = 11;
    localparam int UA_FRAC     = 30;
    localparam int DIV_STEPS   = UA_FRAC + 1;
    localparam int Q_W         = UA_FRAC + 1;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int WIDE_W      = PROD_W + 1;
    localparam int REM_W       = WIDE_W + 1;
    localparam int SQ_IN_W     = 24;
    localparam int SQ_W        = 2 * SQ_IN_W + 1;
    localparam int SS_W        = 2 * SPAN_W;
    localparam int PW          = 36;
    localparam int CNT_W       = 5;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 23'd70044;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_START,
        ST_END_RD0,
        ST_END_RD1,
        ST_END_CMP,
        ST_OVL,
        ST_WALK_RD0,
        ST_WALK_RD1,
        ST_WALK_CMP,
        ST_CLAMP,
        ST_SEG_RD0,
        ST_SEG_RD1,
        ST_SEG_RD2,
        ST_SEG_CAP,
        ST_DIFF,
        ST_MUL1,
        ST_MUL1_WAIT,
        ST_NORM,
        ST_CHK,
        ST_DIV,
        ST_MUL2,
        ST_MUL2_WAIT,
        ST_FIN
    } state_t;

    // Operations of the shared multiplier, in issue order.
    typedef enum logic [3:0] {
        MOP_DEN0,
        MOP_DEN1,
        MOP_NA0,
        MOP_NA1,
        MOP_NB0,
        MOP_NB1,
        MOP_SQ_XA,
        MOP_SQ_YA,
        MOP_SQ_XB,
        MOP_SQ_YB,
        MOP_SQ_S,
        MOP_PX,
        MOP_PY
    } mop_t;

    typedef enum logic [2:0] {
        RD_FIRST,
        RD_LAST,
        RD_MID,
        RD_NEXT,
        RD_PREV
    } rd_sel_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_END0,
        CAP_END1,
        CAP_W0,
        CAP_SM,
        CAP_S0,
        CAP_SP
    } cap_t;

    typedef struct packed {
        logic    load;
        logic    arm;
        logic    kill;
        rd_sel_t rd_sel;
        cap_t    cap;
        logic    walk_step;
        logic    clamp;
        logic    diff;
        logic    mul_en;
        mop_t    mop;
        logic    norm;
        logic    chk;
        logic    div_init;
        logic    div_step;
        logic    fin;
    } cmd_t;

    typedef struct packed {
        logic short_scan;
        logic ovl_ok;
        logic walk_go;
    } sts_t;

    function automatic logic signed [PW-1:0] ext36(input logic [COORD_W-1:0] v);
        ext36 = {{(PW-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic logic signed [MUL_W-1:0] ext33(input logic [COORD_W-1:0] v);
        ext33 = {v[COORD_W-1], v};
    endfunction

    function automatic logic [PW:0] abs_diff(input logic signed [PW-1:0] x,
                                             input logic signed [PW-1:0] y);
        logic signed [PW:0] d;
        d = {x[PW-1], x} - {y[PW-1], y};
        abs_diff = d[PW] ? (PW+1)'(-d) : d;
    endfunction

    function automatic logic [MUL_W-1:0] abs33(input logic signed [MUL_W-1:0] x);
        abs33 = x[MUL_W-1] ? MUL_W'(-x) : x;
    endfunction

endpackage

// File: hdl/scf_ctrl.sv
// Sequencer of the scan crossing finder: load phase, search steps and result hand-off.
`timescale 1ns / 1ps

module scf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_tuser,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  scf_pkg::sts_t sts,
    output scf_pkg::cmd_t cmd
);
    import scf_pkg::*;

    state_t           state_reg, state_next;
    mop_t             mop_reg, mop_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            mop_reg     <= MOP_DEN0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mop_reg     <= mop_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        mop_next     = mop_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        cmd.mop      = mop_reg;
        case (state_reg)
            ST_LOAD: begin
                cmd.load = s_tvalid;
                if (s_tvalid && s_tuser && s_tlast) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.arm  = 1'b1;
                cmd.kill = sts.short_scan;
                state_next = sts.short_scan ? ST_FIN : ST_END_RD0;
            end
            ST_END_RD0: begin
                cmd.rd_sel = RD_FIRST;
                state_next = ST_END_RD1;
            end
            ST_END_RD1: begin
                cmd.rd_sel = RD_LAST;
                cmd.cap    = CAP_END0;
                state_next = ST_END_CMP;
            end
            ST_END_CMP: begin
                cmd.cap    = CAP_END1;
                state_next = ST_OVL;
            end
            ST_OVL: begin
                cmd.kill   = !sts.ovl_ok;
                state_next = sts.ovl_ok ? ST_WALK_RD0 : ST_FIN;
            end
            ST_WALK_RD0: begin
                cmd.rd_sel = RD_MID;
                state_next = ST_WALK_RD1;
            end
            ST_WALK_RD1: begin
                cmd.rd_sel = RD_NEXT;
                cmd.cap    = CAP_W0;
                state_next = ST_WALK_CMP;
            end
            ST_WALK_CMP: begin
                cmd.walk_step = 1'b1;
                state_next    = sts.walk_go ? ST_WALK_RD0 : ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_SEG_RD0;
            end
            ST_SEG_RD0: begin
                cmd.rd_sel = RD_PREV;
                state_next = ST_SEG_RD1;
            end
            ST_SEG_RD1: begin
                cmd.rd_sel = RD_MID;
                cmd.cap    = CAP_SM;
                state_next = ST_SEG_RD2;
            end
            ST_SEG_RD2: begin
                cmd.rd_sel = RD_NEXT;
                cmd.cap    = CAP_S0;
                state_next = ST_SEG_CAP;
            end
            ST_SEG_CAP: begin
                cmd.cap    = CAP_SP;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                mop_next   = MOP_DEN0;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_en = 1'b1;
                if (mop_reg == MOP_SQ_S) begin
                    state_next = ST_MUL1_WAIT;
                end else begin
                    mop_next = mop_t'(mop_reg + 4'd1);
                end
            end
            ST_MUL1_WAIT: begin
                state_next = ST_NORM;
            end
            ST_NORM: begin
                cmd.norm   = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cmd.chk      = 1'b1;
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    mop_next   = MOP_PX;
                    state_next = ST_MUL2;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL2: begin
                cmd.mul_en = 1'b1;
                if (mop_reg == MOP_PY) begin
                    state_next = ST_MUL2_WAIT;
                end else begin
                    mop_next = mop_t'(mop_reg + 4'd1);
                end
            end
            ST_MUL2_WAIT: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.fin      = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// File: hdl/scf_dp.sv
// Datapath of the scan crossing finder: point stores, walk compare, multiplier, divider.
`timescale 1ns / 1ps

module scf_dp #(
    parameter int MAX_POINTS = 2048
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  scf_pkg::cmd_t                  cmd,
    output scf_pkg::sts_t                  sts,
    input  logic [scf_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    input  logic                           cfg_we,
    input  logic [scf_pkg::SPAN_W-1:0]     cfg_data,
    output logic [scf_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser
);
    import scf_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [S_TDATA_W-1:0] ref_mem_reg [MAX_POINTS];
    logic [S_TDATA_W-1:0] cur_mem_reg [MAX_POINTS];
    logic [S_TDATA_W-1:0] rd_ref_reg, rd_cur_reg;

    logic [CW-1:0]     ref_count_reg, cur_count_reg;
    logic              ref_closed_reg, good_reg, op_vld_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [CW-1:0]     a_reg, b_reg;

    logic [CW-1:0] ref_wa, ref_cnt_next, ra_addr, ca_addr;
    logic          ref_room, cur_room, ref_we, cur_we;

    logic signed [COORD_W-1:0] r_first_reg, c_first_reg;
    logic signed [COORD_W-1:0] rmin_reg, rmax_reg, cmin_reg, cmax_reg;
    logic signed [COORD_W-1:0] r_last, c_last;
    logic [S_TDATA_W-1:0] w_r0_reg, w_c0_reg;
    logic [S_TDATA_W-1:0] ref_m_reg, ref_p_reg, cur_m_reg, cur_p_reg;
    logic [COORD_W-1:0]   ref_0_reg, cur_0_reg;

    logic signed [MUL_W-1:0]  dxa_reg, dya_reg, dxb_reg, dyb_reg, ex_reg, ey_reg;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    mop_t                     op_reg;
    logic signed [WIDE_W-1:0] den_reg, na_reg, nb_reg, prod_ext;
    logic [SQ_W-1:0]          sqa_reg, sqb_reg;
    logic [SS_W-1:0]          ss_reg;
    logic signed [PW-1:0]     px_reg, py_reg;
    logic                     num_ok_reg;
    logic [REM_W-1:0]         rem_reg, den_u, rem_sub;
    logic                     rem_ge;
    logic [Q_W-1:0]           q_reg;

    logic [MUL_W-1:0] axa, aya, axb, ayb, span_ext;
    logic             step_a, step_b, wc1, wc2, wc3, wc4;
    logic [CW-1:0]    a_new, b_new, nr_m2, nc_m2;
    logic [CW-1:0]    ref_near, cur_near;
    logic [CW+IDX_OUT_W-1:0] ref_near_ext, cur_near_ext;
    logic             px_ok, tl_a, tl_b, found_w;
    logic [PW:0]      here_r, here_c;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_found_reg;

    // Loading of points into the stores.
    assign ref_wa       = ref_closed_reg ? '0 : ref_count_reg;
    assign ref_room     = ref_wa < CW'(MAX_POINTS);
    assign cur_room     = cur_count_reg < CW'(MAX_POINTS);
    assign ref_cnt_next = ref_room ? ref_wa + 1'b1 : ref_wa;
    assign ref_we       = cmd.load && !s_tuser && ref_room;
    assign cur_we       = cmd.load && s_tuser && cur_room;

    always_comb begin
        case (cmd.rd_sel)
            RD_FIRST: begin
                ra_addr = '0;
                ca_addr = '0;
            end
            RD_LAST: begin
                ra_addr = ref_count_reg - 1'b1;
                ca_addr = cur_count_reg - 1'b1;
            end
            RD_NEXT: begin
                ra_addr = a_reg + 1'b1;
                ca_addr = b_reg + 1'b1;
            end
            RD_PREV: begin
                ra_addr = a_reg - 1'b1;
                ca_addr = b_reg - 1'b1;
            end
            default: begin
                ra_addr = a_reg;
                ca_addr = b_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ref_we) begin
            ref_mem_reg[ref_wa[IW-1:0]] <= s_tdata;
        end
        rd_ref_reg <= ref_mem_reg[ra_addr[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cur_we) begin
            cur_mem_reg[cur_count_reg[IW-1:0]] <= s_tdata;
        end
        rd_cur_reg <= cur_mem_reg[ca_addr[IW-1:0]];
    end

    // Walk decision: rd data holds the points after a and b.
    assign wc1 = abs_diff(ext36(rd_ref_reg[31:0]), ext36(w_c0_reg[31:0]))
               < abs_diff(ext36(w_r0_reg[31:0]), ext36(w_c0_reg[31:0]));
    assign wc2 = abs_diff(ext36(rd_cur_reg[31:0]), ext36(w_r0_reg[31:0]))
               < abs_diff(ext36(w_c0_reg[31:0]), ext36(w_r0_reg[31:0]));
    assign wc3 = abs_diff(ext36(rd_ref_reg[63:32]), ext36(w_c0_reg[63:32]))
               < abs_diff(ext36(w_r0_reg[63:32]), ext36(w_c0_reg[63:32]));
    assign wc4 = abs_diff(ext36(rd_cur_reg[63:32]), ext36(w_r0_reg[63:32]))
               < abs_diff(ext36(w_c0_reg[63:32]), ext36(w_r0_reg[63:32]));

    assign step_a = wc1 || (!wc2 && wc3);
    assign step_b = !wc1 && (wc2 || (!wc3 && wc4));
    assign a_new  = a_reg + CW'(step_a);
    assign b_new  = b_reg + CW'(step_b);
    assign nr_m2  = ref_count_reg - CW'(2);
    assign nc_m2  = cur_count_reg - CW'(2);

    assign sts.short_scan = (ref_count_reg < CW'(3)) || (cur_count_reg < CW'(3));
    assign sts.ovl_ok     = !((cmin_reg > rmax_reg) || (cmax_reg < rmin_reg));
    assign sts.walk_go    = (step_a || step_b)
                          && ({1'b0, a_new} + 1'b1 < {1'b0, ref_count_reg})
                          && ({1'b0, b_new} + 1'b1 < {1'b0, cur_count_reg});

    assign r_last = $signed(rd_ref_reg[31:0]);
    assign c_last = $signed(rd_cur_reg[31:0]);

    // Shared multiplier operands.
    assign axa = abs33(dxa_reg);
    assign aya = abs33(dya_reg);
    assign axb = abs33(dxb_reg);
    assign ayb = abs33(dyb_reg);
    assign span_ext = {{(MUL_W-SPAN_W){1'b0}}, span_reg};

    always_comb begin
        case (cmd.mop)
            MOP_DEN0: begin mul_a = dyb_reg; mul_b = dxa_reg; end
            MOP_DEN1: begin mul_a = dxb_reg; mul_b = dya_reg; end
            MOP_NA0:  begin mul_a = dxb_reg; mul_b = ey_reg;  end
            MOP_NA1:  begin mul_a = dyb_reg; mul_b = ex_reg;  end
            MOP_NB0:  begin mul_a = dxa_reg; mul_b = ey_reg;  end
            MOP_NB1:  begin mul_a = dya_reg; mul_b = ex_reg;  end
            MOP_SQ_XA: begin
                mul_a = {{(MUL_W-SQ_IN_W){1'b0}}, axa[SQ_IN_W-1:0]};
                mul_b = mul_a;
            end
            MOP_SQ_YA: begin
                mul_a = {{(MUL_W-SQ_IN_W){1'b0}}, aya[SQ_IN_W-1:0]};
                mul_b = mul_a;
            end
            MOP_SQ_XB: begin
                mul_a = {{(MUL_W-SQ_IN_W){1'b0}}, axb[SQ_IN_W-1:0]};
                mul_b = mul_a;
            end
            MOP_SQ_YB: begin
                mul_a = {{(MUL_W-SQ_IN_W){1'b0}}, ayb[SQ_IN_W-1:0]};
                mul_b = mul_a;
            end
            MOP_SQ_S: begin
                mul_a = span_ext;
                mul_b = span_ext;
            end
            MOP_PX: begin
                mul_a = {{(MUL_W-Q_W){1'b0}}, q_reg};
                mul_b = dxa_reg;
            end
            MOP_PY: begin
                mul_a = {{(MUL_W-Q_W){1'b0}}, q_reg};
                mul_b = dya_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_ext = {prod_reg[PROD_W-1], prod_reg};

    // Restoring divider step, one quotient bit per cycle.
    assign den_u   = {1'b0, den_reg};
    assign rem_ge  = rem_reg >= den_u;
    assign rem_sub = rem_reg - den_u;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_count_reg  <= '0;
            cur_count_reg  <= '0;
            ref_closed_reg <= 1'b0;
            span_reg       <= SPAN_RESET;
            good_reg       <= 1'b0;
            op_vld_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                span_reg <= cfg_data;
            end
            if (cmd.load && !s_tuser) begin
                ref_count_reg  <= ref_cnt_next;
                ref_closed_reg <= s_tlast;
            end
            if (cur_we) begin
                cur_count_reg <= cur_count_reg + 1'b1;
            end
            if (cmd.fin) begin
                cur_count_reg <= '0;
            end
            if (cmd.kill) begin
                good_reg <= 1'b0;
            end else if (cmd.arm) begin
                good_reg <= 1'b1;
            end
            op_vld_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.arm) begin
            a_reg <= CW'(1);
            b_reg <= CW'(1);
        end else if (cmd.walk_step) begin
            a_reg <= a_new;
            b_reg <= b_new;
        end else if (cmd.clamp) begin
            if (a_reg > nr_m2) begin
                a_reg <= nr_m2;
            end
            if (b_reg > nc_m2) begin
                b_reg <= nc_m2;
            end
        end

        case (cmd.cap)
            CAP_END0: begin
                r_first_reg <= $signed(rd_ref_reg[31:0]);
                c_first_reg <= $signed(rd_cur_reg[31:0]);
            end
            CAP_END1: begin
                rmax_reg <= (r_first_reg < r_last) ? r_last : r_first_reg;
                rmin_reg <= (r_first_reg < r_last) ? r_first_reg : r_last;
                cmax_reg <= (c_first_reg < c_last) ? c_last : c_first_reg;
                cmin_reg <= (c_first_reg < c_last) ? c_first_reg : c_last;
            end
            CAP_W0: begin
                w_r0_reg <= rd_ref_reg;
                w_c0_reg <= rd_cur_reg;
            end
            CAP_SM: begin
                ref_m_reg <= rd_ref_reg;
                cur_m_reg <= rd_cur_reg;
            end
            CAP_S0: begin
                ref_0_reg <= rd_ref_reg[31:0];
                cur_0_reg <= rd_cur_reg[31:0];
            end
            CAP_SP: begin
                ref_p_reg <= rd_ref_reg;
                cur_p_reg <= rd_cur_reg;
            end
            default: ;
        endcase

        if (cmd.diff) begin
            dxa_reg <= ext33(ref_p_reg[31:0])  - ext33(ref_m_reg[31:0]);
            dya_reg <= ext33(ref_p_reg[63:32]) - ext33(ref_m_reg[63:32]);
            dxb_reg <= ext33(cur_p_reg[31:0])  - ext33(cur_m_reg[31:0]);
            dyb_reg <= ext33(cur_p_reg[63:32]) - ext33(cur_m_reg[63:32]);
            ex_reg  <= ext33(ref_m_reg[31:0])  - ext33(cur_m_reg[31:0]);
            ey_reg  <= ext33(ref_m_reg[63:32]) - ext33(cur_m_reg[63:32]);
        end

        prod_reg <= mul_a * mul_b;
        op_reg   <= cmd.mop;

        if (op_vld_reg) begin
            case (op_reg)
                MOP_DEN0:  den_reg <= prod_ext;
                MOP_DEN1:  den_reg <= den_reg - prod_ext;
                MOP_NA0:   na_reg  <= prod_ext;
                MOP_NA1:   na_reg  <= na_reg - prod_ext;
                MOP_NB0:   nb_reg  <= prod_ext;
                MOP_NB1:   nb_reg  <= nb_reg - prod_ext;
                MOP_SQ_XA: sqa_reg <= {1'b0, prod_reg[SQ_W-2:0]};
                MOP_SQ_YA: sqa_reg <= sqa_reg + {1'b0, prod_reg[SQ_W-2:0]};
                MOP_SQ_XB: sqb_reg <= {1'b0, prod_reg[SQ_W-2:0]};
                MOP_SQ_YB: sqb_reg <= sqb_reg + {1'b0, prod_reg[SQ_W-2:0]};
                MOP_SQ_S:  ss_reg  <= prod_reg[SS_W-1:0];
                MOP_PX: begin
                    px_reg <= ext36(ref_m_reg[31:0])
                            + $signed(prod_reg[PROD_W-1:UA_FRAC]);
                end
                MOP_PY: begin
                    py_reg <= ext36(ref_m_reg[63:32])
                            + $signed(prod_reg[PROD_W-1:UA_FRAC]);
                end
                default: ;
            endcase
        end

        if (cmd.norm && den_reg[WIDE_W-1]) begin
            den_reg <= -den_reg;
            na_reg  <= -na_reg;
            nb_reg  <= -nb_reg;
        end

        if (cmd.chk) begin
            num_ok_reg <= (den_reg != '0) && !na_reg[WIDE_W-1] && !nb_reg[WIDE_W-1]
                       && (na_reg <= den_reg) && (nb_reg <= den_reg);
        end

        if (cmd.div_init) begin
            rem_reg <= {1'b0, na_reg};
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? {rem_sub[REM_W-2:0], 1'b0} : {rem_reg[REM_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], rem_ge};
        end

        if (cmd.fin) begin
            out_found_reg <= found_w;
            out_data_reg  <= found_w ? {2'b00, cur_near_ext[IDX_OUT_W-1:0],
                                        ref_near_ext[IDX_OUT_W-1:0],
                                        py_reg[COORD_W-1:0], px_reg[COORD_W-1:0]}
                                     : '0;
        end
    end

    // Final checks and nearest-point refinement.
    assign px_ok = !((px_reg > ext36(rmax_reg)) || (px_reg < ext36(rmin_reg)));
    assign tl_a  = (axa > span_ext) || (aya > span_ext) || (sqa_reg > SQ_W'(ss_reg));
    assign tl_b  = (axb > span_ext) || (ayb > span_ext) || (sqb_reg > SQ_W'(ss_reg));
    assign found_w = good_reg && num_ok_reg && px_ok && !tl_a && !tl_b;

    assign here_r = abs_diff(px_reg, ext36(ref_0_reg));
    assign here_c = abs_diff(px_reg, ext36(cur_0_reg));

    always_comb begin
        if (abs_diff(px_reg, ext36(ref_p_reg[31:0])) < here_r) begin
            ref_near = a_reg + 1'b1;
        end else if (abs_diff(px_reg, ext36(ref_m_reg[31:0])) < here_r) begin
            ref_near = a_reg - 1'b1;
        end else begin
            ref_near = a_reg;
        end
        if (abs_diff(px_reg, ext36(cur_p_reg[31:0])) < here_c) begin
            cur_near = b_reg + 1'b1;
        end else if (abs_diff(px_reg, ext36(cur_m_reg[31:0])) < here_c) begin
            cur_near = b_reg - 1'b1;
        end else begin
            cur_near = b_reg;
        end
    end

    assign ref_near_ext = {{IDX_OUT_W{1'b0}}, ref_near};
    assign cur_near_ext = {{IDX_OUT_W{1'b0}}, cur_near};

    assign m_tdata = out_data_reg;
    assign m_tuser = out_found_reg;

endmodule

// File: hdl/scan_crossing_finder.sv
// Top level of the scan crossing finder: sequencer plus datapath.
`timescale 1ns / 1ps

// Channel  | direction | beat contents
// s_       | in        | tdata {dec, ra}, tuser req_type, tlast is_last
// m_       | out       | tdata {pad, curr_index, ref_index, cross_dec, cross_ra}, tuser found
// cfg_     | in        | cfg_data max_segment_span
//
// Point beats are taken only while the block is loading. The current-scan beat
// with tlast set starts a search; a short scan or a missed RA overlap ends it
// early. The walk is paced by the single read port of each point store (two
// reads, then a compare, per walk step), the tail by the restoring divider and
// the shared 33x33 multiplier (13 products).
// Reset is synchronous and active low; it empties both scans and restores the
// span register. A stalled result beat holds in the output register, and loading
// of the next scan goes on behind it; only the next result waits for the slot.

module scan_crossing_finder #(
    parameter int MAX_POINTS = 2048
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [scf_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] ra, [63:32] dec
    input  logic                          s_tuser,   // [0] req_type
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [scf_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] cross_ra, [63:32] cross_dec,
                                                     // [74:64] ref_index,
                                                     // [85:75] curr_index, [87:86] zero
    output logic                          m_tuser,   // [0] found
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [scf_pkg::SPAN_W-1:0]    cfg_data   // max_segment_span
);
    import scf_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic cfg_we;

    // The span register takes a write in any cycle.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    scf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    scf_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hdl/scf_checker.sv
// Port-level assertions of the scan crossing finder and their bind.
`timescale 1ns / 1ps

module scf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [scf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import scf_pkg::*;

    // A held result beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A miss carries an all-zero payload.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss result with nonzero payload");

    // The search start closes the input until the search is over. An older
    // result beat may still be waiting in the output register.
    a_search_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && s_tlast |=> !s_tready)
        else $error("input open right after search start");

    // Reset empties the result slot.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind scan_crossing_finder scf_checker u_scf_checker (.*);
